>>> rtl/core/keyframe_linear_sampler_core_defines.svh
// Assertion helpers for the keyframe sampler checker.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef KEYFRAME_LINEAR_SAMPLER_CORE_DEFINES_SVH
`define KEYFRAME_LINEAR_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication
`define KLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/kls_pkg.sv
package kls_pkg;

  localparam int unsigned MaxKeys = 64;
  localparam int unsigned KeyIdxW = $clog2(MaxKeys);
  localparam int unsigned KeyCntW = $clog2(MaxKeys + 1);
  localparam int unsigned CfgW    = 7;
  localparam int unsigned FracW   = 16;
  localparam int unsigned DivCntW = $clog2(FracW);

  localparam logic [31:0] OneQ16 = 32'h0001_0000;

  // action codes
  localparam logic ActLoad   = 1'b0;
  localparam logic ActSample = 1'b1;

  typedef struct packed {
    logic               action;
    logic [5:0]         key_index;
    logic [31:0]        key_time;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic signed [31:0] value_w;
    logic [31:0]        sample_time;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               status;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] key_time;
    logic [31:0] val_x;
    logic [31:0] val_y;
    logic [31:0] val_z;
    logic [31:0] val_w;
  } key_entry_t;

endpackage

>>> rtl/core/kls_keymem.sv
module kls_keymem (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [kls_pkg::KeyIdxW-1:0]          waddr_i,
  input  kls_pkg::key_entry_t                  wdata_i,
  input  logic [kls_pkg::KeyIdxW-1:0]          raddr_i,
  output kls_pkg::key_entry_t                  rdata_o
);

  kls_pkg::key_entry_t key_mem_q [kls_pkg::MaxKeys];
  kls_pkg::key_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= key_mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/kls_div.sv
module kls_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                num_i,
  input  logic [31:0]                den_i,
  output logic                       done_o,
  output logic [kls_pkg::FracW-1:0]  quot_o
);

  // restoring division, one quotient bit per cycle; expects num < den
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [kls_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [31:0]                   rem_q, rem_d;
  logic [31:0]                   den_q, den_d;
  logic [kls_pkg::FracW-1:0]     quot_q, quot_d;
  logic [32:0]                   rem_x2;
  logic [32:0]                   rem_sub;
  logic                          ge;

  assign rem_x2  = {rem_q, 1'b0};
  assign ge      = rem_x2 >= {1'b0, den_q};
  assign rem_sub = rem_x2 - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sub[31:0] : rem_x2[31:0];
      quot_d = {quot_q[kls_pkg::FracW-2:0], ge};
      cnt_d  = kls_pkg::DivCntW'(cnt_q + 1'b1);
      if (cnt_q == kls_pkg::DivCntW'(kls_pkg::FracW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/core/kls_mix.sv
module kls_mix (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [31:0]                a_i,
  input  logic [31:0]                b_i,
  input  logic [kls_pkg::FracW-1:0]  t_i,
  output logic [31:0]                res_o
);

  // a + floor((b - a) * t / 2^16); product registered, add on the next cycle
  logic signed [32:0] diff;
  logic signed [49:0] prod_d;
  logic signed [49:0] prod_q;
  logic signed [31:0] a_q;
  logic signed [33:0] sum;

  assign diff   = $signed({b_i[31], b_i}) - $signed({a_i[31], a_i});
  assign prod_d = diff * $signed({1'b0, t_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= $signed(a_i);
    end
  end

  // arithmetic shift by 16 is the floor
  assign sum   = $signed({{2{a_q[31]}}, a_q}) + prod_q[49:16];
  assign res_o = sum[31:0];

endmodule

>>> rtl/core/keyframe_linear_sampler_core.sv
// Keyframe sampler: a load beat writes one table entry and gives no result.
// Sample beats: accept, then scan the keys in order (up to 64); for an interior
// hit the divider forms 16 quotient bits and the multiplier blends the result,
// which is then handed off; one sample at a time.
// The scan reads one key at a time through the single read port of the key memory.
// Reset (rst_ni low, async) clears key_count and control; the table is not cleared.
module keyframe_linear_sampler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  kls_pkg::in_beat_t             in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output kls_pkg::out_beat_t            out_beat_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kls_pkg::CfgW-1:0]      cfg_data_i
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StDiv  = 5'b00100,
    StMix  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic [kls_pkg::CfgW-1:0]        key_count_q, key_count_d;
  logic                            out_valid_q, out_valid_d;
  kls_pkg::out_beat_t              out_q, out_d;
  kls_pkg::out_beat_t              res_q, res_d;
  logic [kls_pkg::KeyIdxW-1:0]     cmp_i_q, cmp_i_d;
  logic [31:0]                     time_q, time_d;
  kls_pkg::key_entry_t             prev_q, prev_d;
  kls_pkg::key_entry_t             next_q, next_d;
  logic [kls_pkg::FracW-1:0]       t_q, t_d;
  logic [2:0]                      comp_q, comp_d;

  logic                            in_accept;
  logic                            out_free;
  logic                            out_load;
  logic [kls_pkg::KeyCntW-1:0]     n_keys;
  logic [kls_pkg::KeyIdxW-1:0]     last_idx;
  logic [1:0]                      cap_idx;

  // key memory port
  logic                            mem_we;
  logic [kls_pkg::KeyIdxW-1:0]     mem_waddr;
  kls_pkg::key_entry_t             mem_wdata;
  logic [kls_pkg::KeyIdxW-1:0]     mem_raddr;
  kls_pkg::key_entry_t             mem_rdata;

  // divider and multiplier (the multiplier is shared by the four components)
  logic                            div_start;
  logic [31:0]                     div_num;
  logic [31:0]                     div_den;
  logic                            div_done;
  logic [kls_pkg::FracW-1:0]       div_quot;
  logic                            mix_en;
  logic [31:0]                     mix_a;
  logic [31:0]                     mix_b;
  logic [31:0]                     mix_res;

  // handshakes
  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_load    = (state_q == StDone) & out_free;

  // active key count, saturated at table depth
  assign n_keys   = (32'(key_count_q) > kls_pkg::MaxKeys) ?
                    kls_pkg::KeyCntW'(kls_pkg::MaxKeys) : kls_pkg::KeyCntW'(key_count_q);
  assign last_idx = kls_pkg::KeyIdxW'(n_keys - 1'b1);

  // load write path
  assign mem_waddr = kls_pkg::KeyIdxW'(in_beat_i.key_index);
  assign mem_wdata = '{key_time: in_beat_i.key_time,
                       val_x:    in_beat_i.value_x,
                       val_y:    in_beat_i.value_y,
                       val_z:    in_beat_i.value_z,
                       val_w:    in_beat_i.value_w};

  // scan reads run one address ahead of the compare; key 0 is issued on accept
  assign mem_raddr = (state_q == StScan) ? kls_pkg::KeyIdxW'(cmp_i_q + 1'b1) : '0;

  // divider operands: interior hit, prev time <= sample < next time
  assign div_num = time_q - prev_q.key_time;
  assign div_den = mem_rdata.key_time - prev_q.key_time;

  // component selection for the multiplier, one per cycle
  always_comb begin
    case (comp_q[1:0])
      2'd0:    begin mix_a = prev_q.val_x; mix_b = next_q.val_x; end
      2'd1:    begin mix_a = prev_q.val_y; mix_b = next_q.val_y; end
      2'd2:    begin mix_a = prev_q.val_z; mix_b = next_q.val_z; end
      default: begin mix_a = prev_q.val_w; mix_b = next_q.val_w; end
    endcase
  end

  assign cap_idx = 2'(comp_q - 1'b1);

  always_comb begin
    state_d     = state_q;
    key_count_d = cfg_valid_i ? cfg_data_i : key_count_q;
    cmp_i_d     = cmp_i_q;
    time_d      = time_q;
    prev_d      = prev_q;
    next_d      = next_q;
    t_d         = t_q;
    comp_d      = comp_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    mix_en      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (in_beat_i.action == kls_pkg::ActLoad) begin
            mem_we = (32'(in_beat_i.key_index) < kls_pkg::MaxKeys);
          end else begin
            time_d  = in_beat_i.sample_time;
            cmp_i_d = '0;
            if (n_keys == '0) begin
              // empty table: identity default, status set
              res_d   = '{out_x: '0, out_y: '0, out_z: '0,
                          out_w: kls_pkg::OneQ16, status: 1'b1};
              state_d = StDone;
            end else begin
              state_d = StScan;
            end
          end
        end
      end

      StScan: begin
        if (mem_rdata.key_time > time_q) begin
          if (cmp_i_q == '0) begin
            // before the first key: t clamps to 0, key 0 comes out
            res_d   = '{out_x: mem_rdata.val_x, out_y: mem_rdata.val_y,
                        out_z: mem_rdata.val_z, out_w: mem_rdata.val_w,
                        status: 1'b0};
            state_d = StDone;
          end else begin
            next_d       = mem_rdata;
            div_start    = 1'b1;
            res_d.status = 1'b0;
            state_d      = StDiv;
          end
        end else begin
          prev_d = mem_rdata;
          if (cmp_i_q == last_idx) begin
            // at or past the last key: prev and next coincide
            res_d   = '{out_x: mem_rdata.val_x, out_y: mem_rdata.val_y,
                        out_z: mem_rdata.val_z, out_w: mem_rdata.val_w,
                        status: 1'b0};
            state_d = StDone;
          end else begin
            cmp_i_d = kls_pkg::KeyIdxW'(cmp_i_q + 1'b1);
          end
        end
      end

      StDiv: begin
        if (div_done) begin
          t_d     = div_quot;
          comp_d  = '0;
          state_d = StMix;
        end
      end

      StMix: begin
        // issue component comp_q, collect component comp_q - 1
        mix_en = ~comp_q[2];
        if (comp_q != '0) begin
          case (cap_idx)
            2'd0:    res_d.out_x = mix_res;
            2'd1:    res_d.out_y = mix_res;
            2'd2:    res_d.out_z = mix_res;
            default: res_d.out_w = mix_res;
          endcase
        end
        comp_d = 3'(comp_q + 1'b1);
        if (comp_q[2]) begin
          state_d = StDone;
        end
      end

      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register decouples the result side from the sequencer
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);
  assign out_d       = out_load ? res_q : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      key_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_count_q <= key_count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    res_q   <= res_d;
    cmp_i_q <= cmp_i_d;
    time_q  <= time_d;
    prev_q  <= prev_d;
    next_q  <= next_d;
    t_q     <= t_d;
    comp_q  <= comp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  kls_keymem u_keymem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  kls_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  kls_mix u_mix (
    .clk_i (clk_i),
    .en_i  (mix_en),
    .a_i   (mix_a),
    .b_i   (mix_b),
    .t_i   (t_q),
    .res_o (mix_res)
  );

endmodule

>>> rtl/core/kls_core_checker.sv
`include "keyframe_linear_sampler_core_defines.svh"

module kls_core_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input kls_pkg::in_beat_t  in_beat_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input kls_pkg::out_beat_t out_beat_o
);

  `KLS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat_o), "result beat dropped or changed while stalled")

  `KLS_ASSERT_NEXT(a_sample_busy, in_valid_i && !in_stall_o && in_beat_i.action == kls_pkg::ActSample, in_stall_o, "sample beat accepted but input not stalled next cycle")

  `KLS_ASSERT_NOW(a_result_after_busy, $rose(out_valid_o), $past(in_stall_o), "result beat appeared without a sample in progress")

  `KLS_ASSERT_NOW(a_empty_default, out_valid_o && out_beat_o.status, out_beat_o.out_x == '0 && out_beat_o.out_y == '0 && out_beat_o.out_z == '0 && out_beat_o.out_w == kls_pkg::OneQ16, "empty-table result is not the identity default")

endmodule

bind keyframe_linear_sampler_core kls_core_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

>>> tb/sv/keyframe_linear_sampler_core_tb.sv
`timescale 1ns / 100ps

module keyframe_linear_sampler_core_tb;

  // status codes of a result beat
  localparam logic StatusInterp = 1'b0;
  localparam logic StatusEmpty  = 1'b1;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned SettleCycles = 10;   // margin for a trailing load
  localparam int unsigned DrainCycles  = 120;  // margin for one worst-case sample
  localparam int unsigned HoldCycles   = 400;  // long receiver hold-off
  localparam int unsigned NumPhases    = 10;
  localparam int unsigned SamplesPerPh = 30;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  kls_pkg::in_beat_t        in_beat_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  kls_pkg::out_beat_t       out_beat_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [kls_pkg::CfgW-1:0] cfg_data_i = '0;

  keyframe_linear_sampler_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  kls_pkg::in_beat_t  pending_q [$];   // beats waiting to be offered, front is on the bus
  kls_pkg::out_beat_t lerp_q [$];      // interpolation results still owed by the block

  // predictor's copy of the key table and of key_count
  logic [31:0]              tab_time [kls_pkg::MaxKeys];
  logic signed [31:0]       tab_val  [kls_pkg::MaxKeys][4];
  logic [kls_pkg::CfgW-1:0] key_count_q = '0;

  // generator's view of key times, used to aim sample times at keys
  logic [31:0] plan_time [kls_pkg::MaxKeys];

  bit          in_fire;        // input beat taken at the last rising edge
  bit          idle_on = 1'b1; // random idling on both sides
  bit          rx_hold_req;
  int unsigned rx_hold_left, rx_gap, in_gap;
  int unsigned err_cnt, n_loads, n_samples, n_results, n_empty, n_settings;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // a + floor((b - a) * frac / 2^16), difference kept wide so nothing wraps
  function automatic logic signed [31:0] blend(logic signed [31:0] a,
                                               logic signed [31:0] b,
                                               longint frac);
    longint     sa, prod;
    logic [63:0] r;
    sa   = a;
    prod = (longint'(b) - sa) * frac;
    r    = sa + (prod >>> 16);  // arithmetic shift is floor division
    return r[31:0];
  endfunction

  function automatic kls_pkg::out_beat_t lerp_sample(logic [31:0] qt);
    kls_pkg::out_beat_t r;
    int unsigned        n, lo, hi, i;
    bit                 hit;
    longint             num, den, frac;
    r = '0;
    n = (key_count_q > kls_pkg::MaxKeys) ? kls_pkg::MaxKeys : key_count_q;
    if (n == 0) begin
      r.out_w  = kls_pkg::OneQ16;
      r.status = StatusEmpty;
      return r;
    end
    // lo: last key at or before qt, hi: first key after it
    lo  = 0;
    hi  = 0;
    hit = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!hit) begin
        if (tab_time[i] > qt) begin
          hi  = i;
          hit = 1'b1;
        end else begin
          lo = i;
        end
      end
    end
    // no later key, or the first key is already later: pair with the last key
    if (hi == 0) hi = n - 1;
    num = longint'({32'h0, qt}) - longint'({32'h0, tab_time[lo]});
    den = longint'({32'h0, tab_time[hi]}) - longint'({32'h0, tab_time[lo]});
    // zero or negative span and queries before lo give the earlier key
    if (den <= 0 || num <= 0) frac = 0;
    else if (num >= den) frac = longint'(kls_pkg::OneQ16);
    else frac = (num << 16) / den;
    r.out_x  = blend(tab_val[lo][0], tab_val[hi][0], frac);
    r.out_y  = blend(tab_val[lo][1], tab_val[hi][1], frac);
    r.out_z  = blend(tab_val[lo][2], tab_val[hi][2], frac);
    r.out_w  = blend(tab_val[lo][3], tab_val[hi][3], frac);
    r.status = StatusInterp;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: outputs and handshakes are sampled at the rising edge.
  // Results are checked first, then an accepted input beat updates the model.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    kls_pkg::out_beat_t want;
    kls_pkg::in_beat_t  b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lerp_q.size() == 0) begin
        $error("result beat with nothing expected: %h", out_beat_o);
        err_cnt++;
      end else begin
        want = lerp_q.pop_front();
        check_field("out_x",  want.out_x,  out_beat_o.out_x);
        check_field("out_y",  want.out_y,  out_beat_o.out_y);
        check_field("out_z",  want.out_z,  out_beat_o.out_z);
        check_field("out_w",  want.out_w,  out_beat_o.out_w);
        check_field("status", 32'(want.status), 32'(out_beat_o.status));
        n_results++;
        if (want.status == StatusEmpty) n_empty++;
      end
    end
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) begin
      b = pending_q.pop_front();
      if (b.action == kls_pkg::ActLoad) begin
        tab_time[b.key_index]   = b.key_time;
        tab_val[b.key_index][0] = b.value_x;
        tab_val[b.key_index][1] = b.value_y;
        tab_val[b.key_index][2] = b.value_z;
        tab_val[b.key_index][3] = b.value_w;
      end else begin
        lerp_q.push_back(lerp_sample(b.sample_time));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: inputs change at the falling edge. A beat on the bus is held until
  // taken; idle bursts only start once the bus is free.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (in_valid_i && !in_fire) begin
      // stalled: payload and valid stay put
    end else if (in_gap != 0) begin
      in_gap--;
      in_valid_i <= 1'b0;
    end else if (idle_on && $urandom_range(99) < 12) begin
      in_gap = $urandom_range(17, 0);  // start an idle burst
      in_valid_i <= 1'b0;
    end else if (pending_q.size() != 0) begin
      in_valid_i <= 1'b1;
      in_beat_i  <= pending_q[0];
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and stalls its input.
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = HoldCycles;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(99) < 10) begin
      rx_gap = $urandom_range(17, 0);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_load(int unsigned idx, logic [31:0] kt, logic [31:0] vx,
                           logic [31:0] vy, logic [31:0] vz, logic [31:0] vw);
    kls_pkg::in_beat_t b;
    b.action      = kls_pkg::ActLoad;
    b.key_index   = idx[kls_pkg::KeyIdxW-1:0];
    b.key_time    = kt;
    b.value_x     = vx;
    b.value_y     = vy;
    b.value_z     = vz;
    b.value_w     = vw;
    b.sample_time = $urandom;  // don't care for loads
    pending_q.push_back(b);
    plan_time[idx[kls_pkg::KeyIdxW-1:0]] = kt;
    n_loads++;
  endtask

  task automatic push_sample(logic [31:0] qt);
    kls_pkg::in_beat_t b;
    b.action      = kls_pkg::ActSample;
    b.key_index   = kls_pkg::KeyIdxW'($urandom);  // key fields are don't care for samples
    b.key_time    = $urandom;
    b.value_x     = $urandom;
    b.value_y     = $urandom;
    b.value_z     = $urandom;
    b.value_w     = $urandom;
    b.sample_time = qt;
    pending_q.push_back(b);
    n_samples++;
  endtask

  // component values, biased toward the extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // sample time aimed at, just around, or between keys of the active range
  function automatic logic [31:0] pick_time(int unsigned n);
    int unsigned j;
    logic [31:0] at;
    j  = $urandom_range(n - 1, 0);
    at = plan_time[j];
    case ($urandom_range(9))
      0:       return at;
      1:       return at - 1;
      2:       return at + 1;
      3:       return 32'h0000_0000;
      4:       return 32'hFFFF_FFFF;
      5:       return $urandom;
      default: begin
        if (j + 1 < n && plan_time[j + 1] > at)
          return at + $urandom_range(plan_time[j + 1] - at, 0);
        return at + $urandom_range(255, 0);
      end
    endcase
  endfunction

  // fresh sorted table in entries 0..n-1; zero gaps give equal times
  task automatic build_table(int unsigned n);
    logic [31:0] kt, gap_max, gap;
    int unsigned i;
    kt      = ($urandom_range(3) == 0) ? 32'h0 : $urandom_range(32'h4000_0000, 0);
    gap_max = (32'hFFFF_FFFF - kt) / (n + 1);
    if ($urandom_range(1) == 0 && gap_max > 32'h0004_0000) gap_max = 32'h0004_0000;
    for (i = 0; i < n; i++) begin
      push_load(i, kt, pick_value(), pick_value(), pick_value(), pick_value());
      gap = ($urandom_range(7) == 0) ? 32'h0 : $urandom_range(gap_max, 1);
      kt  = kt + gap;
    end
  endtask

  function automatic int unsigned phase_keys(int unsigned k);
    case (k)
      0:       return kls_pkg::MaxKeys;
      1:       return 3;
      2:       return 1;
      3:       return 0;
      4:       return 20;
      5:       return 2;
      6:       return kls_pkg::MaxKeys;
      7:       return 12;
      9:       return kls_pkg::MaxKeys;
      default: return $urandom_range(kls_pkg::MaxKeys, 1);
    endcase
  endfunction

  // wait until every beat is taken and every result has come back
  task automatic settle();
    while (pending_q.size() != 0 || in_valid_i || lerp_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // key_count is only written with the block idle
  task automatic set_key_count(int unsigned n);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= kls_pkg::CfgW'(n);
    do @(posedge clk_i); while (!cfg_ready_o);
    key_count_q = kls_pkg::CfgW'(n);
    n_settings++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned k, i, n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table gives the (0,0,0,1) default
    set_key_count(0);
    push_sample(32'h0000_0000);
    push_sample(32'hFFFF_FFFF);

    // write every entry once, sorted one second apart, so no sample ever
    // reaches an entry that was never written
    for (i = 0; i < kls_pkg::MaxKeys; i++)
      push_load(i, (i + 1) << 16, pick_value(), pick_value(), pick_value(), pick_value());

    // single key: zero span, before/at/after
    set_key_count(1);
    push_sample(32'h0000_0000);
    push_sample(32'h0001_0000);
    push_sample(32'hFFFF_FFFF);

    // two keys swinging across the full signed range
    set_key_count(2);
    push_load(0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    push_load(1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    push_sample(32'h0000_0000);
    push_sample(32'h0001_0000);
    push_sample(32'h0001_0001);
    push_sample(32'h0002_0000);
    push_sample(32'h0002_FFFF);
    push_sample(32'h0003_0000);

    // equal times, then an out-of-order key that gives a negative span
    set_key_count(3);
    push_load(1, 32'h0001_0000, pick_value(), pick_value(), pick_value(), pick_value());
    push_load(2, 32'h0000_8000, pick_value(), pick_value(), pick_value(), pick_value());
    push_sample(32'h0001_0000);
    push_sample(32'h0000_FFFF);
    push_sample(32'h0000_9000);

    // keys at both ends of the time range: widest division
    set_key_count(2);
    push_load(0, 32'h0000_0000, pick_value(), pick_value(), pick_value(), pick_value());
    push_load(1, 32'hFFFF_FFFF, pick_value(), pick_value(), pick_value(), pick_value());
    push_sample(32'h0000_0001);
    push_sample(32'h8000_0000);
    push_sample(32'hFFFF_FFFE);

    // random phases, one key_count setting each
    for (k = 0; k < NumPhases; k++) begin
      n = phase_keys(k);
      if (k == NumPhases - 1) idle_on = 1'b0;  // last stretch runs flat out
      set_key_count(n);
      if (n != 0 && (n <= 24 || $urandom_range(2) == 0)) build_table(n);
      for (i = 0; i < SamplesPerPh; i++) begin
        case ($urandom_range(9))
          0:       push_load($urandom_range(kls_pkg::MaxKeys - 1, 0), $urandom,
                             $urandom, $urandom, $urandom, $urandom);
          1:       push_sample($urandom);
          default: push_sample((n == 0) ? $urandom : pick_time(n));
        endcase
      end
      // receiver holds off while the sender keeps offering samples
      if (k == 1) rx_hold_req = 1'b1;
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d loads and %0d samples across %0d key_count settings (0, 1, 2, 64, ...).",
             n_loads, n_samples, n_settings);
    $display("Checked %0d result beats, %0d empty-table defaults; %0d mismatches.",
             n_results, n_empty, err_cnt);
    if (err_cnt == 0 && lerp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
